@@ design/ipat_pkg.sv @@
// shared types and constants of the ip address text parser
package ipat_pkg;

    localparam int CHAR_W  = 21;
    localparam int CNT_W   = 7;
    localparam int GROUP_W = 16;
    localparam int OCTET_W = 8;
    localparam int ADDR_W  = 64;

    // length limits of the two text forms, in characters
    localparam int V6_MAX_LEN = 40;
    localparam int V4_MAX_LEN = 16;

    localparam logic [CNT_W-1:0]  COUNT_CAP = '1;
    localparam logic [CHAR_W-1:0] CH_COLON  = 21'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT    = 21'h2E;
    localparam logic [CHAR_W-1:0] CH_STAR   = 21'h2A;

    localparam logic [GROUP_W-1:0] GROUP_ALL_ONES = 16'hFFFF;
    localparam logic [OCTET_W-1:0] OCTET_MAX      = 8'd255;

    typedef struct packed {
        logic [CNT_W-1:0]              char_count;
        logic                          colon_seen;
        logic                          first_is_star;
        logic [7:0][GROUP_W-1:0]       hex_groups;
        logic [3:0]                    group_index;
        logic [3:0]                    compress_pos;
        logic                          compress_present;
        logic [GROUP_W-1:0]            group_hex_accum;
        logic [2:0]                    group_char_count;
        logic                          prev_char_colon;
        logic                          mapped_tail_mode;
        logic [3:0][OCTET_W-1:0]       dotted_octets;
        logic [2:0]                    octet_index;
        logic [8:0]                    octet_accum;
        logic                          octet_has_digit;
        logic                          v6_error;
        logic                          v4_error;
    } ipat_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic              valid_res;
        logic              wildcard_res;
    } ipat_result_t;

endpackage

@@ design/ipat_text_if.sv @@
// request channel carrying one character of address text
interface ipat_text_if import ipat_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

@@ design/ipat_addr_if.sv @@
// request channel carrying one parsed address
interface ipat_addr_if import ipat_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic              valid_res;
    logic              wildcard_res;

    modport source (output valid, output addr_high, output addr_low, output valid_res,
                    output wildcard_res, input ready);
    modport sink (input valid, input addr_high, input addr_low, input valid_res,
                  input wildcard_res, output ready);
endinterface

@@ design/ip_address_text_parser.sv @@
// top level of the ip address text parser
//
// The block takes an address string one character per request on the text
// channel, with last marking the final character, and gives one request on
// the addr channel for each string: the 128-bit address in network byte
// order (addr_high holds bytes 0 to 7), valid_res when the text is a valid
// IPv6 or dotted-quad IPv4 address, and wildcard_res when the text is a lone
// asterisk. IPv6 text may use one "::" and an IPv4-mapped tail after ffff;
// a dotted quad is returned as ::ffff:a.b.c.d. An invalid string gives a
// zero address with valid_res low. The block takes one character every
// cycle, string after string, with no gap between strings. The result of a
// string is registered: its last character sits in the input register while
// the single-pass step and assembly logic computes the result, which is
// then written into the result register. Only a stalled addr channel holds
// up the text channel, and then only once a final character is waiting
// behind a full result register.
module ip_address_text_parser import ipat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ipat_text_if.sink   text,
    ipat_addr_if.source addr
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              in_last_reg, in_last_next;

    // parse state
    ipat_state_t state_reg, state_next;
    ipat_state_t state_step;

    // result register
    logic         out_valid_reg, out_valid_next;
    ipat_result_t out_res_reg, out_res_next;
    ipat_result_t result;

    logic text_take;
    logic out_free;
    logic step_go;

    ipat_parse u_parse (
        .state      (state_reg),
        .character  (in_char_reg),
        .last       (in_last_reg),
        .state_step (state_step),
        .result     (result)
    );

    // a final character needs room in the result register, others always move
    assign out_free   = !out_valid_reg || addr.ready;
    assign step_go    = in_valid_reg && (!in_last_reg || out_free);
    assign text.ready = !in_valid_reg || step_go;
    assign text_take  = text.valid && text.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        in_last_next  = in_last_reg;
        if (text_take)
        begin
            in_valid_next = 1'b1;
            in_char_next  = text.character;
            in_last_next  = text.last;
        end
        else if (step_go)
            in_valid_next = 1'b0;
    end

    // state starts over after every final character
    always_comb
    begin
        state_next = state_reg;
        if (step_go)
            state_next = in_last_reg ? '0 : state_step;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (step_go && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_res_next   = result;
        end
        else if (addr.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
        in_last_reg <= in_last_next;
        out_res_reg <= out_res_next;
    end

    assign addr.valid        = out_valid_reg;
    assign addr.addr_high    = out_res_reg.addr_high;
    assign addr.addr_low     = out_res_reg.addr_low;
    assign addr.valid_res    = out_res_reg.valid_res;
    assign addr.wildcard_res = out_res_reg.wildcard_res;

    // parse state is fresh after a final character is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        step_go && in_last_reg |=> state_reg.char_count == '0 && !state_reg.colon_seen)
        else $error("parse state not cleared after final character");

    // an invalid result carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.valid_res |->
            out_res_reg.addr_high == '0 && out_res_reg.addr_low == '0)
        else $error("invalid result with nonzero address");

    // wildcard and valid address never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.valid_res && out_res_reg.wildcard_res))
        else $error("wildcard flagged as valid address");

    // a result only follows a processed final character
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_go && in_last_reg))
        else $error("result without final character");

endmodule

@@ design/ipat_parse.sv @@
// per-character parse step and end-of-string address assembly
module ipat_parse import ipat_pkg::*;
(
    input  ipat_state_t       state,
    input  logic [CHAR_W-1:0] character,
    input  logic              last,
    output ipat_state_t       state_step,
    output ipat_result_t      result
);

    localparam logic [CNT_W-1:0] V6_LIMIT = CNT_W'(V6_MAX_LEN);
    localparam logic [CNT_W-1:0] V4_LIMIT = CNT_W'(V4_MAX_LEN);

    function automatic ipat_state_t close_group(input ipat_state_t s, input logic may_fill);
        ipat_state_t r;
        r = s;
        if (s.group_index < 4'd8)
            r.hex_groups[s.group_index[2:0]] = s.group_hex_accum;
        if (s.group_index < 4'd15)
            r.group_index = s.group_index + 4'd1;
        r.group_hex_accum  = '0;
        r.group_char_count = '0;
        if (r.group_index > 4'd8 || (r.group_index == 4'd8 && !may_fill))
            r.v6_error = 1'b1;
        return r;
    endfunction

    function automatic ipat_state_t enter_tail(input ipat_state_t s);
        ipat_state_t r;
        logic        bad;
        r   = s;
        bad = 1'b0;
        if (s.group_index < 4'd1 || s.group_index > 4'd8)
            bad = 1'b1;
        else if (s.hex_groups[3'(s.group_index - 4'd1)] != GROUP_ALL_ONES)
            bad = 1'b1;
        else if (!s.compress_present && s.group_index != 4'd6)
            bad = 1'b1;
        else begin
            for (int k = 0; k < 8; k++)
                if (4'(k + 1) < s.group_index && s.hex_groups[k] != '0)
                    bad = 1'b1;
        end
        if (bad)
            r.v6_error = 1'b1;
        else
            r.mapped_tail_mode = 1'b1;
        return r;
    endfunction

    ipat_state_t n;

    // step logic for one character
    always_comb
    begin
        logic        skip;
        logic        is_hex;
        logic [3:0]  hex_val;
        logic [11:0] dec_sum;
        logic [CNT_W-1:0] pos;

        n       = state;
        pos     = state.char_count;
        skip    = 1'b0;
        is_hex  = 1'b1;
        hex_val = character[3:0];
        dec_sum = '0;

        if (character inside {[21'h30:21'h39]})
            hex_val = character[3:0];
        else if (character inside {[21'h41:21'h46], [21'h61:21'h66]})
            hex_val = character[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        if (n.char_count != COUNT_CAP)
            n.char_count = n.char_count + CNT_W'(1);
        if (pos == '0 && character == CH_STAR)
            n.first_is_star = 1'b1;
        if (character == CH_COLON)
            n.colon_seen = 1'b1;

        // ipv6 side
        if (!n.v6_error && !n.mapped_tail_mode)
        begin
            if (n.prev_char_colon)
            begin
                n.prev_char_colon = 1'b0;
                skip = 1'b1;
                if (character == CH_COLON)
                begin
                    if (n.compress_present)
                        n.v6_error = 1'b1;
                    else
                    begin
                        n.compress_present = 1'b1;
                        n.compress_pos = (pos == CNT_W'(1)) ? n.group_index
                                                            : n.group_index + 4'd1;
                        n = close_group(n, last);
                    end
                end
                else if (n.group_char_count == '0)
                    n.v6_error = 1'b1;
                else
                begin
                    n = close_group(n, 1'b0);
                    skip = n.v6_error;
                end
            end
            if (!skip)
            begin
                if (character == CH_COLON)
                begin
                    if (last)
                        n.v6_error = 1'b1;
                    else
                        n.prev_char_colon = 1'b1;
                end
                else if (n.group_char_count >= 3'd4)
                    n.v6_error = 1'b1;
                else if (is_hex)
                begin
                    n.group_hex_accum  = {n.group_hex_accum[11:0], hex_val};
                    n.group_char_count = n.group_char_count + 3'd1;
                end
                else if (character == CH_DOT)
                    n = enter_tail(n);
                else
                    n.v6_error = 1'b1;
            end
        end

        // dotted quad side, restarted at every colon before the tail
        if (character == CH_COLON && !n.mapped_tail_mode)
        begin
            n.octet_index     = '0;
            n.octet_accum     = '0;
            n.octet_has_digit = 1'b0;
            n.v4_error        = 1'b0;
        end
        else if (!n.v4_error)
        begin
            if (character == CH_DOT)
            begin
                if (!n.octet_has_digit)
                    n.v4_error = 1'b1;
                else
                begin
                    if (n.octet_index < 3'd4)
                        n.dotted_octets[n.octet_index[1:0]] = n.octet_accum[7:0];
                    n.octet_index     = n.octet_index + 3'd1;
                    n.octet_accum     = '0;
                    n.octet_has_digit = 1'b0;
                    if (n.octet_index > 3'd3)
                        n.v4_error = 1'b1;
                end
            end
            else if (character inside {[21'h30:21'h39]})
            begin
                dec_sum = 12'(n.octet_accum) * 12'd10 + 12'(character[3:0]);
                n.octet_has_digit = 1'b1;
                if (dec_sum > 12'(OCTET_MAX))
                    n.v4_error = 1'b1;
                else
                    n.octet_accum = dec_sum[8:0];
            end
            else
                n.v4_error = 1'b1;
        end
    end

    assign state_step = n;

    // end-of-string assembly from the stepped state
    always_comb
    begin
        ipat_state_t             m;
        logic                    quad_ok;
        logic                    v6_ok;
        logic [ADDR_W-1:0]       mapped;
        logic [3:0]              gap;
        logic [4:0]              gap_end;
        logic [7:0][GROUP_W-1:0] w;

        quad_ok = !n.v4_error && n.octet_has_digit && n.octet_index == 3'd3;
        mapped  = {16'h0000, GROUP_ALL_ONES, n.dotted_octets[0], n.dotted_octets[1],
                   n.dotted_octets[2], n.octet_accum[7:0]};

        m = n;
        if (m.group_char_count != '0)
            m = close_group(m, 1'b1);
        v6_ok = !n.v6_error && !m.v6_error && m.group_index <= 4'd8;
        if (!m.compress_present)
        begin
            if (m.group_index != 4'd8)
                v6_ok = 1'b0;
        end
        else if (m.compress_pos > 4'd7 || m.compress_pos > m.group_index)
            v6_ok = 1'b0;
        gap     = 4'd8 - m.group_index;
        gap_end = 5'(m.compress_pos) + 5'(gap);
        for (int k = 0; k < 8; k++)
        begin
            if (!m.compress_present || 4'(k) < m.compress_pos)
                w[k] = m.hex_groups[k];
            else if (5'(k) < gap_end)
                w[k] = '0;
            else
                w[k] = m.hex_groups[3'(4'(k) - gap)];
        end

        result = '0;
        if (n.char_count == CNT_W'(1) && n.first_is_star)
            result.wildcard_res = 1'b1;
        else if (n.colon_seen && n.char_count < V6_LIMIT)
        begin
            if (n.mapped_tail_mode)
            begin
                if (!n.v6_error && quad_ok)
                begin
                    result.valid_res = 1'b1;
                    result.addr_low  = mapped;
                end
            end
            else if (v6_ok)
            begin
                result.valid_res = 1'b1;
                result.addr_high = {w[0], w[1], w[2], w[3]};
                result.addr_low  = {w[4], w[5], w[6], w[7]};
            end
        end
        else if (!n.colon_seen && n.char_count < V4_LIMIT && quad_ok)
        begin
            result.valid_res = 1'b1;
            result.addr_low  = mapped;
        end
    end

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the ip address text parser
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ipat_pkg::*;

    typedef logic [CHAR_W-1:0] char_t;

    // largest code point the text channel is meant to carry
    localparam int unsigned MAX_CODE_POINT = 1114111;
    localparam int unsigned RANDOM_CHARS   = 320;
    localparam int unsigned RANDOM_STRINGS = 20;

    logic clk;
    logic rst_n;

    ipat_text_if text_ch ();
    ipat_addr_if addr_ch ();

    ip_address_text_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .addr  (addr_ch)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor: a character-by-character parse of the address text
    // ------------------------------------------------------------------

    // length of the text so far, saturating at the counter's top value
    int unsigned        txt_len;
    bit                 saw_colon;
    bit                 lead_star;

    // ipv6 side: finished groups, the group being read, and the "::" place
    logic [GROUP_W-1:0] grp_val [8];
    int unsigned        grp_idx;
    int unsigned        gap_at;
    bit                 has_gap;
    logic [GROUP_W-1:0] grp_acc;
    int unsigned        grp_digits;
    bit                 colon_pending;
    bit                 in_tail;
    bit                 v6_bad;

    // dotted-quad side, also used for the mapped tail of ipv6 text
    logic [OCTET_W-1:0] quad_val [4];
    int unsigned        quad_idx;
    int unsigned        quad_acc;
    bit                 quad_digit;
    bit                 v4_bad;

    // parsed addresses waiting for the block to return them
    ipat_result_t       addr_expected [$];

    function automatic void restart_quad();
        quad_idx   = 0;
        quad_acc   = 0;
        quad_digit = 1'b0;
        v4_bad     = 1'b0;
    endfunction

    function automatic void reset_parse();
        txt_len       = 0;
        saw_colon     = 1'b0;
        lead_star     = 1'b0;
        grp_idx       = 0;
        gap_at        = 0;
        has_gap       = 1'b0;
        grp_acc       = '0;
        grp_digits    = 0;
        colon_pending = 1'b0;
        in_tail       = 1'b0;
        v6_bad        = 1'b0;
        for (int k = 0; k < 8; k++)
            grp_val[k] = '0;
        for (int k = 0; k < 4; k++)
            quad_val[k] = '0;
        restart_quad();
    endfunction

    function automatic int hex_digit_value(char_t ch);
        if (ch >= "0" && ch <= "9")
            return int'(ch) - 'h30;
        if (ch >= "a" && ch <= "f")
            return int'(ch) - 'h61 + 10;
        if (ch >= "A" && ch <= "F")
            return int'(ch) - 'h41 + 10;
        return -1;
    endfunction

    // close the group being read; the eighth group may only close at the end
    function automatic void close_hex_group(bit may_fill);
        if (grp_idx < 8)
            grp_val[grp_idx] = grp_acc;
        if (grp_idx < 15)
            grp_idx++;
        grp_acc    = '0;
        grp_digits = 0;
        if (grp_idx > 8 || (grp_idx == 8 && !may_fill))
            v6_bad = 1'b1;
    endfunction

    // a dot inside an ipv6 group: only legal right after ffff with zeros before
    function automatic void start_mapped_tail();
        if (grp_idx < 1 || grp_idx > 8)
        begin
            v6_bad = 1'b1;
            return;
        end
        if (grp_val[grp_idx-1] != GROUP_ALL_ONES)
        begin
            v6_bad = 1'b1;
            return;
        end
        if (!has_gap && grp_idx != 6)
        begin
            v6_bad = 1'b1;
            return;
        end
        for (int k = 0; k + 1 < grp_idx; k++)
        begin
            if (grp_val[k] != '0)
            begin
                v6_bad = 1'b1;
                return;
            end
        end
        in_tail = 1'b1;
    endfunction

    function automatic void step_ipv6(char_t ch, int unsigned pos, bit lst);
        int hv;
        if (v6_bad || in_tail)
            return;
        if (colon_pending)
        begin
            colon_pending = 1'b0;
            if (ch == CH_COLON)
            begin
                // a second "::" in one string is never allowed
                if (has_gap)
                begin
                    v6_bad = 1'b1;
                    return;
                end
                has_gap = 1'b1;
                gap_at  = (pos == 1) ? grp_idx : grp_idx + 1;
                close_hex_group(lst);
                return;
            end
            if (grp_digits == 0)
            begin
                v6_bad = 1'b1;
                return;
            end
            close_hex_group(1'b0);
            if (v6_bad)
                return;
        end
        if (ch == CH_COLON)
        begin
            if (lst)
            begin
                v6_bad = 1'b1;
                return;
            end
            colon_pending = 1'b1;
            return;
        end
        if (grp_digits >= 4)
        begin
            v6_bad = 1'b1;
            return;
        end
        hv = hex_digit_value(ch);
        if (hv >= 0)
        begin
            grp_acc = {grp_acc[GROUP_W-5:0], hv[3:0]};
            grp_digits++;
        end
        else if (ch == CH_DOT)
            start_mapped_tail();
        else
            v6_bad = 1'b1;
    endfunction

    function automatic void step_quad(char_t ch);
        int unsigned t;
        // outside a mapped tail every colon starts the quad over
        if (ch == CH_COLON && !in_tail)
        begin
            restart_quad();
            return;
        end
        if (v4_bad)
            return;
        if (ch == CH_DOT)
        begin
            if (!quad_digit)
            begin
                v4_bad = 1'b1;
                return;
            end
            if (quad_idx < 4)
                quad_val[quad_idx] = quad_acc[OCTET_W-1:0];
            quad_idx++;
            quad_acc   = 0;
            quad_digit = 1'b0;
            if (quad_idx > 3)
                v4_bad = 1'b1;
        end
        else if (ch >= "0" && ch <= "9")
        begin
            t = quad_acc * 10 + (int'(ch) - 'h30);
            quad_digit = 1'b1;
            if (t > OCTET_MAX)
                v4_bad = 1'b1;
            else
                quad_acc = t;
        end
        else
            v4_bad = 1'b1;
    endfunction

    function automatic bit quad_complete();
        if (v4_bad || !quad_digit || quad_idx != 3)
            return 1'b0;
        quad_val[3] = quad_acc[OCTET_W-1:0];
        return 1'b1;
    endfunction

    // ::ffff:a.b.c.d, low half
    function automatic logic [ADDR_W-1:0] mapped_quad();
        return {16'h0000, GROUP_ALL_ONES, quad_val[0], quad_val[1], quad_val[2], quad_val[3]};
    endfunction

    function automatic bit ipv6_complete(output logic [ADDR_W-1:0] hi,
                                         output logic [ADDR_W-1:0] lo);
        logic [GROUP_W-1:0] w [8];
        int unsigned        n;
        int unsigned        fill;
        hi = '0;
        lo = '0;
        if (v6_bad)
            return 1'b0;
        if (grp_digits > 0)
            close_hex_group(1'b1);
        if (v6_bad)
            return 1'b0;
        n = grp_idx;
        if (n > 8)
            return 1'b0;
        if (!has_gap)
        begin
            if (n != 8)
                return 1'b0;
        end
        else if (gap_at > 7 || gap_at > n)
            return 1'b0;
        // groups after "::" move to the end, the hole is zero-filled
        fill = 8 - n;
        for (int unsigned k = 0; k < 8; k++)
        begin
            if (!has_gap || k < gap_at)
                w[k] = grp_val[k];
            else if (k < gap_at + fill)
                w[k] = '0;
            else
                w[k] = grp_val[(k - fill) & 7];
        end
        hi = {w[0], w[1], w[2], w[3]};
        lo = {w[4], w[5], w[6], w[7]};
        return 1'b1;
    endfunction

    // one accepted character; returns 1 with the address when the string ends
    function automatic bit predict_char(char_t ch, bit lst, output ipat_result_t res);
        int unsigned       pos;
        bit                ok;
        bit                star;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        res = '0;
        pos = txt_len;
        if (txt_len < COUNT_CAP)
            txt_len++;
        if (pos == 0 && ch == CH_STAR)
            lead_star = 1'b1;
        if (ch == CH_COLON)
            saw_colon = 1'b1;
        step_ipv6(ch, pos, lst);
        step_quad(ch);
        if (!lst)
            return 1'b0;
        ok   = 1'b0;
        star = 1'b0;
        hi   = '0;
        lo   = '0;
        if (txt_len == 1 && lead_star)
            star = 1'b1;
        else if (saw_colon && txt_len < V6_MAX_LEN)
        begin
            if (in_tail)
            begin
                ok = !v6_bad && quad_complete();
                if (ok)
                    lo = mapped_quad();
            end
            else
                ok = ipv6_complete(hi, lo);
        end
        else if (!saw_colon && txt_len < V4_MAX_LEN)
        begin
            ok = quad_complete();
            if (ok)
                lo = mapped_quad();
        end
        if (!ok)
        begin
            hi = '0;
            lo = '0;
        end
        res.addr_high    = hi;
        res.addr_low     = lo;
        res.valid_res    = ok;
        res.wildcard_res = star;
        reset_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // text side: one character per request
    // ------------------------------------------------------------------

    char_t       text_buf [$];
    int unsigned chars_sent;
    int unsigned strings_sent;
    bit          steady;
    int unsigned hold_cycles;
    bit          failed;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_char(char_t ch, bit lst);
        int unsigned  gap;
        ipat_result_t res;
        gap = sender_gap();
        // idle cycles carry junk that must be ignored
        repeat (gap)
        begin
            @(negedge clk);
            text_ch.valid     <= 1'b0;
            text_ch.character <= char_t'($urandom_range(0, MAX_CODE_POINT));
            text_ch.last      <= 1'(($urandom));
        end
        @(negedge clk);
        text_ch.valid     <= 1'b1;
        text_ch.character <= ch;
        text_ch.last      <= lst;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        if (predict_char(ch, lst, res))
            addr_expected.push_back(res);
        chars_sent++;
    endtask

    // send the buffered text as one string, marking its final character
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        strings_sent++;
        text_buf.delete();
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(char_t'(s[i]));
    endtask

    task automatic send_string(string s);
        put_str(s);
        send_text();
    endtask

    // stop offering text and let every outstanding address come back
    task automatic drain_results();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (addr_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random text builders
    // ------------------------------------------------------------------

    function automatic char_t hex_char(int unsigned v);
        if (v < 10)
            return char_t'('h30 + v);
        if ($urandom_range(0, 1) != 0)
            return char_t'('h41 + v - 10);
        return char_t'('h61 + v - 10);
    endfunction

    function automatic char_t random_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return hex_char($urandom_range(0, 15));
        if (r < 60)
            return CH_COLON;
        if (r < 75)
            return CH_DOT;
        if (r < 80)
            return CH_STAR;
        if (r < 92)
            return char_t'($urandom_range('h20, 'h7E));
        return char_t'($urandom_range(0, MAX_CODE_POINT));
    endfunction

    task automatic put_hex_group();
        int unsigned n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 4;
        repeat (n)
            text_buf.push_back(hex_char($urandom_range(0, 15)));
    endtask

    task automatic put_zero_group();
        repeat ($urandom_range(1, 4))
            text_buf.push_back("0");
    endtask

    task automatic put_ffff();
        repeat (4)
            text_buf.push_back(hex_char(15));
    endtask

    task automatic put_octet();
        int unsigned v;
        if ($urandom_range(0, 19) == 0)
            v = $urandom_range(256, 999);
        else if ($urandom_range(0, 3) == 0)
            v = ($urandom_range(0, 1) != 0) ? 255 : 0;
        else
            v = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0)
            put_str("0");
        put_str($sformatf("%0d", v));
    endtask

    task automatic put_quad();
        for (int k = 0; k < 4; k++)
        begin
            if (k != 0)
                text_buf.push_back(CH_DOT);
            put_octet();
        end
    endtask

    // eight groups, or up to eight around one "::"
    task automatic put_ipv6();
        bit          squeeze;
        int unsigned n;
        int unsigned p;
        squeeze = $urandom_range(0, 3) != 0;
        n = squeeze ? $urandom_range(0, 8) : 8;
        p = squeeze ? $urandom_range(0, n) : n;
        for (int unsigned k = 0; k < p; k++)
        begin
            put_hex_group();
            if (k + 1 < p)
                text_buf.push_back(CH_COLON);
        end
        if (squeeze)
            put_str("::");
        for (int unsigned k = p; k < n; k++)
        begin
            put_hex_group();
            if (k + 1 < n)
                text_buf.push_back(CH_COLON);
        end
    endtask

    // ipv4-mapped ipv6 text, now and then with a wrong prefix
    task automatic put_mapped();
        case ($urandom_range(0, 4))
            0:
            begin
                put_str("::");
                put_ffff();
            end
            1:
            begin
                repeat (5)
                begin
                    put_zero_group();
                    text_buf.push_back(CH_COLON);
                end
                put_ffff();
            end
            2:
            begin
                put_zero_group();
                put_str("::");
                put_ffff();
            end
            3:
            begin
                put_str("::");
                put_zero_group();
                text_buf.push_back(CH_COLON);
                put_ffff();
            end
            default:
            begin
                put_hex_group();
                put_str("::");
                put_hex_group();
            end
        endcase
        text_buf.push_back(CH_COLON);
        put_quad();
    endtask

    task automatic mutate_text();
        int unsigned idx;
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: text_buf[idx] = random_char();
            1: if (text_buf.size() > 1) text_buf.delete(idx);
            2: text_buf.insert(idx, random_char());
            default: text_buf.push_back(random_char());
        endcase
    endtask

    task automatic build_random_text();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 28)
            put_ipv6();
        else if (r < 43)
            put_mapped();
        else if (r < 66)
            put_quad();
        else if (r < 70)
        begin
            // star alone or with company
            text_buf.push_back(CH_STAR);
            if ($urandom_range(0, 1) != 0)
                text_buf.push_back(random_char());
        end
        else if (r < 88)
        begin
            // well-formed text with a few random edits
            case ($urandom_range(0, 2))
                0: put_ipv6();
                1: put_mapped();
                default: put_quad();
            endcase
            repeat ($urandom_range(1, 2))
                mutate_text();
        end
        else
        begin
            // noise, rarely long enough to saturate the length count
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 135)
                                             : $urandom_range(1, 45);
            repeat (n)
                text_buf.push_back(random_char());
        end
        if (text_buf.size() == 0)
            text_buf.push_back(random_char());
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    task automatic test_wildcard();
        send_string("*");
        send_string("**");
        send_string("1*");
    endtask

    task automatic test_dotted_quad();
        send_string("0.0.0.0");
        send_string("255.255.255.255");
        send_string("256.1.1.1");
        send_string("01.002.3.4");
        send_string("1..2.3");
        send_string("1.2.3.4.5");
        // sixteen characters is one too many for a dotted quad
        send_string("0255.255.255.255");
    endtask

    task automatic test_ipv6_plain();
        // 39 characters, the longest legal ipv6 text
        send_string("ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff");
        send_string("1:2:3:4:5:6:7:8");
        send_string("1:2:3:4:5:6:7:8:9");
        send_string("1:2:3:4:5:6:7:");
        send_string("12345::");
        send_string(":1:2:3:4:5:6:7");
    endtask

    task automatic test_ipv6_compression();
        send_string("::");
        send_string("::1");
        send_string("1::");
        send_string("1::2::3");
        send_string("abcd:EF01::9");
        send_string("1:2:3:4:5:6:7::");
    endtask

    task automatic test_mapped_tail();
        send_string("::ffff:10.0.0.1");
        send_string("0:0:0:0:0:FFFF:1.2.3.4");
        send_string("1:0:0:0:0:ffff:1.2.3.4");
        send_string("::fffe:1.2.3.4");
        send_string("::ffff:1.2.3.4:5");
    endtask

    task automatic test_odd_characters();
        // top code point after a dotted quad prefix
        put_str("1.2.3.");
        text_buf.push_back(char_t'(MAX_CODE_POINT));
        send_text();
        // a code point whose low byte looks like a colon
        put_str("1:");
        text_buf.push_back(char_t'('h10003A));
        put_str("2");
        send_text();
        text_buf.push_back('0);
        send_text();
        send_string("g::");
        send_string("1.2.3.4 ");
    endtask

    // no idling on either side for a stretch of strings
    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (12)
        begin
            build_random_text();
            send_text();
        end
        steady = 1'b0;
    endtask

    // receiver holds off while strings keep coming, then the sender waits
    task automatic test_backpressure();
        drain_results();
        hold_cycles = 300;
        repeat (10)
        begin
            put_quad();
            send_text();
        end
        drain_results();
    endtask

    task automatic test_random_text();
        int unsigned first_char;
        int unsigned first_string;
        first_char   = chars_sent;
        first_string = strings_sent;
        while (chars_sent - first_char < RANDOM_CHARS ||
               strings_sent - first_string < RANDOM_STRINGS)
        begin
            build_random_text();
            send_text();
            // now and then the sender waits for everything to come back
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // address side: ready with random stalls, and the checker
    // ------------------------------------------------------------------

    initial
    begin : addr_receiver
        int unsigned stall_left;
        int unsigned r;
        stall_left    = 0;
        addr_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                addr_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (steady)
                addr_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                addr_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    addr_ch.ready <= 1'b1;
                else
                begin
                    // the stall starts now and goes on for the picked length after this one
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    addr_ch.ready <= 1'b0;
                end
            end
        end
    end

    ipat_result_t addr_want;

    // every accepted address is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && addr_ch.valid && addr_ch.ready)
        begin
            if (addr_expected.size() == 0)
            begin
                $error("address returned with none pending");
                failed = 1'b1;
            end
            else
            begin
                addr_want = addr_expected.pop_front();
                if (addr_ch.addr_high !== addr_want.addr_high)
                begin
                    $error("addr_high: expected %h, got %h",
                           addr_want.addr_high, addr_ch.addr_high);
                    failed = 1'b1;
                end
                if (addr_ch.addr_low !== addr_want.addr_low)
                begin
                    $error("addr_low: expected %h, got %h",
                           addr_want.addr_low, addr_ch.addr_low);
                    failed = 1'b1;
                end
                if (addr_ch.valid_res !== addr_want.valid_res)
                begin
                    $error("valid_res: expected %b, got %b",
                           addr_want.valid_res, addr_ch.valid_res);
                    failed = 1'b1;
                end
                if (addr_ch.wildcard_res !== addr_want.wildcard_res)
                begin
                    $error("wildcard_res: expected %b, got %b",
                           addr_want.wildcard_res, addr_ch.wildcard_res);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        failed            = 1'b0;
        steady            = 1'b0;
        hold_cycles       = 0;
        chars_sent        = 0;
        strings_sent      = 0;
        text_ch.valid     = 1'b0;
        text_ch.character = '0;
        text_ch.last      = 1'b0;
        reset_parse();
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wildcard();
        test_dotted_quad();
        test_ipv6_plain();
        test_ipv6_compression();
        test_mapped_tail();
        test_odd_characters();
        test_back_to_back();
        test_backpressure();
        test_random_text();

        @(negedge clk);
        text_ch.valid <= 1'b0;
        drain_results();
        // catch any extra results
        repeat (20)
            @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit, far past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
